>>> sv/uflc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Union-find engine package
// Field widths, the sequencer's control word and flags, and the microcode
// program that steps the datapath through one edge.
// ----------------------------------------------------------------------------
package uflc_pkg;

    localparam int NODE_W        = 10;
    localparam int SIZE_W        = 11;
    localparam int CNT_W         = 11;
    localparam int DEF_MAX_NODES = 1024;
    localparam logic [CNT_W-1:0] CNT_RESET = 11'd1024;

    localparam int STEP_W = 5;

    localparam logic [STEP_W-1:0] ST_CLEAR    = 5'd0;
    localparam logic [STEP_W-1:0] ST_IDLE     = 5'd1;
    localparam logic [STEP_W-1:0] ST_CHECK    = 5'd2;
    localparam logic [STEP_W-1:0] ST_FA_RD    = 5'd3;
    localparam logic [STEP_W-1:0] ST_FA_TEST  = 5'd4;
    localparam logic [STEP_W-1:0] ST_FA_RDUP  = 5'd5;
    localparam logic [STEP_W-1:0] ST_FA_HALVE = 5'd6;
    localparam logic [STEP_W-1:0] ST_FB_INIT  = 5'd7;
    localparam logic [STEP_W-1:0] ST_FB_RD    = 5'd8;
    localparam logic [STEP_W-1:0] ST_FB_TEST  = 5'd9;
    localparam logic [STEP_W-1:0] ST_FB_RDUP  = 5'd10;
    localparam logic [STEP_W-1:0] ST_FB_HALVE = 5'd11;
    localparam logic [STEP_W-1:0] ST_J_ROOTB  = 5'd12;
    localparam logic [STEP_W-1:0] ST_J_SZA    = 5'd13;
    localparam logic [STEP_W-1:0] ST_J_SZB    = 5'd14;
    localparam logic [STEP_W-1:0] ST_J_LINK   = 5'd15;
    localparam logic [STEP_W-1:0] ST_FINISH   = 5'd16;

    // Source for the walk pointer.
    typedef enum logic [1:0] {
        V_HOLD  = 2'd0,
        V_LD_A  = 2'd1,
        V_LD_B  = 2'd2,
        V_LD_RD = 2'd3
    } t_vop;

    // Jump conditions.
    typedef enum logic [2:0] {
        C_NEVER    = 3'd0,
        C_ALWAYS   = 3'd1,
        C_IN_FIRE  = 3'd2,
        C_BAD      = 3'd3,
        C_ROOT     = 3'd4,
        C_SAME     = 3'd5,
        C_CLR_LAST = 3'd6,
        C_OUT_FREE = 3'd7
    } t_cond;

    typedef struct packed {
        logic              accept;
        t_vop              v_op;
        logic              p_rd_up;
        logic              s_rd_v;
        logic              ld_p;
        logic              ld_ra;
        logic              ld_sza;
        logic              ld_szb;
        logic              check;
        logic              halve;
        logic              link;
        logic              clear;
        logic              out_ld;
        t_cond             cond;
        logic              stay;
        logic [STEP_W-1:0] target;
    } t_ctrl;

    typedef struct packed {
        logic in_fire;
        logic bad;
        logic root;
        logic same;
        logic clr_last;
        logic out_free;
    } t_flags;

    // The program. A step without a true condition moves to the next step,
    // or stays put when its stay bit is set.
    function automatic t_ctrl uflc_ucode(input logic [STEP_W-1:0] step);
        t_ctrl c;
        c = '0;
        case (step)
            ST_CLEAR: begin
                c.clear  = 1'b1;
                c.cond   = C_CLR_LAST;
                c.target = ST_IDLE;
                c.stay   = 1'b1;
            end
            ST_IDLE: begin
                c.accept = 1'b1;
                c.cond   = C_IN_FIRE;
                c.target = ST_CHECK;
                c.stay   = 1'b1;
            end
            ST_CHECK: begin
                c.check  = 1'b1;
                c.v_op   = V_LD_A;
                c.cond   = C_BAD;
                c.target = ST_FINISH;
            end
            ST_FA_RD, ST_FB_RD: begin
                c.p_rd_up = 1'b0;
            end
            ST_FA_TEST: begin
                c.ld_p   = 1'b1;
                c.cond   = C_ROOT;
                c.target = ST_FB_INIT;
            end
            ST_FA_RDUP, ST_FB_RDUP: begin
                c.p_rd_up = 1'b1;
            end
            ST_FA_HALVE: begin
                c.halve  = 1'b1;
                c.v_op   = V_LD_RD;
                c.cond   = C_ALWAYS;
                c.target = ST_FA_RD;
            end
            ST_FB_INIT: begin
                c.ld_ra = 1'b1;
                c.v_op  = V_LD_B;
            end
            ST_FB_TEST: begin
                c.ld_p   = 1'b1;
                c.cond   = C_ROOT;
                c.target = ST_J_ROOTB;
            end
            ST_FB_HALVE: begin
                c.halve  = 1'b1;
                c.v_op   = V_LD_RD;
                c.cond   = C_ALWAYS;
                c.target = ST_FB_RD;
            end
            ST_J_ROOTB: begin
                c.cond   = C_SAME;
                c.target = ST_FINISH;
            end
            ST_J_SZA: begin
                c.s_rd_v = 1'b1;
                c.ld_sza = 1'b1;
            end
            ST_J_SZB: begin
                c.ld_szb = 1'b1;
            end
            ST_J_LINK: begin
                c.link = 1'b1;
            end
            ST_FINISH: begin
                c.out_ld = 1'b1;
                c.cond   = C_OUT_FREE;
                c.target = ST_IDLE;
                c.stay   = 1'b1;
            end
            default: begin
                c.cond   = C_ALWAYS;
                c.target = ST_IDLE;
            end
        endcase
        return c;
    endfunction

endpackage

>>> sv/uflc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module uflc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/uflc_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Microcode sequencer
// Step counter, program table lookup and conditional jump logic.
// ----------------------------------------------------------------------------
module uflc_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  uflc_pkg::t_flags i_flags,
    output uflc_pkg::t_ctrl  o_ctrl
);
    import uflc_pkg::*;

    logic [STEP_W-1:0] r_pc;
    logic [STEP_W-1:0] n_pc;
    t_ctrl             w_ctrl;
    logic              w_take;

    assign w_ctrl = uflc_ucode(r_pc);

    always_comb begin
        case (w_ctrl.cond)
            C_NEVER:    w_take = 1'b0;
            C_ALWAYS:   w_take = 1'b1;
            C_IN_FIRE:  w_take = i_flags.in_fire;
            C_BAD:      w_take = i_flags.bad;
            C_ROOT:     w_take = i_flags.root;
            C_SAME:     w_take = i_flags.same;
            C_CLR_LAST: w_take = i_flags.clr_last;
            C_OUT_FREE: w_take = i_flags.out_free;
            default:    w_take = 1'b0;
        endcase

        if (w_take) begin
            n_pc = w_ctrl.target;
        end else if (w_ctrl.stay) begin
            n_pc = r_pc;
        end else begin
            n_pc = r_pc + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= ST_CLEAR;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctrl = w_ctrl;

endmodule

>>> sv/union_find_largest_component_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Union-find largest component engine
// Disjoint-set merge with union by size and path halving, reporting the
// size of the largest set after every edge.
// ----------------------------------------------------------------------------
// Each input item is one edge (node_a, node_b), and each produces exactly one
// result item: merged, the largest set size so far, and bad_index when an
// endpoint is not below node_count (then nothing changes). After reset the
// block clears its parent and size memories, one entry a cycle, and accepts
// no item while it clears; node_count writes are taken at any time. One item
// is in work at a time. Every parent link walked on a root search costs two
// reads of the parent memory, whose read data is registered; path halving
// keeps the walks short over time. The next item is accepted while a
// finished result still waits in the output register.
// ----------------------------------------------------------------------------
module union_find_largest_component_top #(
    parameter int MAX_NODES = uflc_pkg::DEF_MAX_NODES
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Configuration: node count.
    input  logic                        i_cfg_we,
    input  logic [uflc_pkg::CNT_W-1:0]  i_cfg_data,
    // Edge input channel.
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [uflc_pkg::NODE_W-1:0] i_node_a,
    input  logic [uflc_pkg::NODE_W-1:0] i_node_b,
    // Result channel.
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_merged,
    output logic [uflc_pkg::SIZE_W-1:0] o_largest_size,
    output logic                        o_bad_index
);
    import uflc_pkg::*;

    // Width of a node index inside the stores.
    localparam int NW = $clog2(MAX_NODES);

    t_ctrl  w_ctrl;
    t_flags w_flags;

    // Configuration register.
    logic [CNT_W-1:0]  r_node_count;

    // Datapath registers.
    logic [NODE_W-1:0] r_a;
    logic [NODE_W-1:0] r_b;
    logic [NW-1:0]     r_v;
    logic [NW-1:0]     n_v;
    logic [NW-1:0]     r_p;
    logic [NW-1:0]     r_ra;
    logic [SIZE_W-1:0] r_sza;
    logic [SIZE_W-1:0] r_szb;
    logic [SIZE_W-1:0] r_max;
    logic [SIZE_W-1:0] n_max;
    logic              r_bad;
    logic              r_merged;
    logic [NW-1:0]     r_clr;

    // Output register.
    logic              r_out_valid;
    logic              r_out_merged;
    logic [SIZE_W-1:0] r_out_largest;
    logic              r_out_bad;

    // Memory ports.
    logic              p_we;
    logic [NW-1:0]     p_waddr;
    logic [NW-1:0]     p_wdata;
    logic [NW-1:0]     p_raddr;
    logic [NW-1:0]     p_rdata;
    logic              s_we;
    logic [NW-1:0]     s_waddr;
    logic [SIZE_W-1:0] s_wdata;
    logic [NW-1:0]     s_raddr;
    logic [SIZE_W-1:0] s_rdata;

    // Combinational helpers.
    logic              w_in_fire;
    logic              w_a_ok;
    logic              w_b_ok;
    logic              w_out_free;
    logic              w_b_bigger;
    logic [NW-1:0]     w_big;
    logic [NW-1:0]     w_small;
    logic [SIZE_W-1:0] w_sum;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    uflc_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_ctrl  (w_ctrl)
    );

    assign o_ready    = w_ctrl.accept;
    assign w_in_fire  = i_valid && o_ready;
    assign w_out_free = !r_out_valid || i_ready;

    // An endpoint is usable when it is below both node_count and the store
    // depth; a node count of zero rejects everything.
    assign w_a_ok = ({1'b0, r_a} < r_node_count) && (32'(r_a) < 32'(MAX_NODES));
    assign w_b_ok = ({1'b0, r_b} < r_node_count) && (32'(r_b) < 32'(MAX_NODES));

    assign w_flags.in_fire  = w_in_fire;
    assign w_flags.bad      = !(w_a_ok && w_b_ok);
    assign w_flags.root     = (p_rdata == r_v);
    assign w_flags.same     = (r_ra == r_v);
    assign w_flags.clr_last = (r_clr == NW'(MAX_NODES - 1));
    assign w_flags.out_free = w_out_free;

    // ------------------------------------------------------------------
    // Union: on equal sizes the root of node_b goes under that of node_a.
    // ------------------------------------------------------------------
    assign w_b_bigger = (r_szb > r_sza);
    assign w_big      = w_b_bigger ? r_v : r_ra;
    assign w_small    = w_b_bigger ? r_ra : r_v;
    assign w_sum      = r_sza + r_szb;

    // ------------------------------------------------------------------
    // Memory port selection
    // ------------------------------------------------------------------
    always_comb begin
        p_we    = w_ctrl.clear || w_ctrl.halve || w_ctrl.link;
        p_waddr = r_clr;
        p_wdata = r_clr;
        if (w_ctrl.halve) begin
            // Relink the visited node to its grandparent.
            p_waddr = r_v;
            p_wdata = p_rdata;
        end else if (w_ctrl.link) begin
            p_waddr = w_small;
            p_wdata = w_big;
        end

        s_we    = w_ctrl.clear || w_ctrl.link;
        s_waddr = r_clr;
        s_wdata = SIZE_W'(1);
        if (w_ctrl.link) begin
            s_waddr = w_big;
            s_wdata = w_sum;
        end

        p_raddr = w_ctrl.p_rd_up ? r_p : r_v;
        s_raddr = w_ctrl.s_rd_v ? r_v : r_ra;
    end

    uflc_ram #(
        .WIDTH (NW),
        .DEPTH (MAX_NODES)
    ) u_parent_ram (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (p_waddr),
        .i_wdata (p_wdata),
        .i_raddr (p_raddr),
        .o_rdata (p_rdata)
    );

    uflc_ram #(
        .WIDTH (SIZE_W),
        .DEPTH (MAX_NODES)
    ) u_size_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    // ------------------------------------------------------------------
    // Next values
    // ------------------------------------------------------------------
    always_comb begin
        case (w_ctrl.v_op)
            V_HOLD:  n_v = r_v;
            V_LD_A:  n_v = NW'(r_a);
            V_LD_B:  n_v = NW'(r_b);
            V_LD_RD: n_v = p_rdata;
            default: n_v = r_v;
        endcase

        n_max = r_max;
        if (w_ctrl.link && (w_sum > r_max)) begin
            n_max = w_sum;
        end
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= CNT_RESET;
            r_max        <= SIZE_W'(1);
            r_clr        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_node_count <= i_cfg_data;
            end
            r_max <= n_max;
            if (w_ctrl.clear) begin
                r_clr <= r_clr + 1'b1;
            end
            if (w_ctrl.out_ld && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_a <= i_node_a;
            r_b <= i_node_b;
        end
        r_v <= n_v;
        if (w_ctrl.ld_p) begin
            r_p <= p_rdata;
        end
        if (w_ctrl.ld_ra) begin
            r_ra <= r_v;
        end
        if (w_ctrl.ld_sza) begin
            r_sza <= s_rdata;
        end
        if (w_ctrl.ld_szb) begin
            r_szb <= s_rdata;
        end
        if (w_ctrl.check) begin
            r_bad    <= w_flags.bad;
            r_merged <= 1'b0;
        end else if (w_ctrl.link) begin
            r_merged <= 1'b1;
        end
        if (w_ctrl.out_ld && w_out_free) begin
            r_out_merged  <= r_merged;
            r_out_largest <= r_max;
            r_out_bad     <= r_bad;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_merged       = r_out_merged;
    assign o_largest_size = r_out_largest;
    assign o_bad_index    = r_out_bad;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // The running maximum only grows between resets.
    a_max_grows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_max >= $past(r_max)))
        else $error("largest set size decreased");

    // Two sets are only joined when their roots differ.
    a_link_distinct : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.link |-> (r_ra != r_v))
        else $error("link issued on a single root");

    // A rejected edge never reports a merge.
    a_bad_no_merge : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_merged && r_out_bad))
        else $error("merge reported for a rejected edge");

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Union-find largest component engine testbench
// Sends edges through the valid/ready input channel and checks every result
// against a disjoint-set predictor kept in step with the block. The predictor
// does union by size and path halving, and tracks the node_count bound.
// Node-count writes happen only while no result is outstanding. Both channels
// idle at random, with calm stretches in between.
// ----------------------------------------------------------------------------
module testbench;

    localparam int NODES = uflc_pkg::DEF_MAX_NODES;

    // Work list kinds: an edge to send, a node-count write, or a pause until
    // every outstanding result has come back.
    typedef enum logic [1:0] {
        JOB_EDGE  = 2'd0,
        JOB_COUNT = 2'd1,
        JOB_DRAIN = 2'd2
    } t_job_kind;

    typedef struct {
        t_job_kind                   kind;
        logic [uflc_pkg::NODE_W-1:0] a;
        logic [uflc_pkg::NODE_W-1:0] b;
        logic [uflc_pkg::CNT_W-1:0]  count;
        int                          gap;
    } t_job;

    typedef struct {
        logic                        merged;
        logic [uflc_pkg::SIZE_W-1:0] largest;
        logic                        bad;
    } t_join_result;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_cfg_we;
    logic [uflc_pkg::CNT_W-1:0]  i_cfg_data;
    logic                        i_valid;
    logic                        o_ready;
    logic [uflc_pkg::NODE_W-1:0] i_node_a;
    logic [uflc_pkg::NODE_W-1:0] i_node_b;
    logic                        o_valid;
    logic                        i_ready;
    logic                        o_merged;
    logic [uflc_pkg::SIZE_W-1:0] o_largest_size;
    logic                        o_bad_index;

    union_find_largest_component_top #(
        .MAX_NODES(NODES)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_node_a       (i_node_a),
        .i_node_b       (i_node_b),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_merged       (o_merged),
        .o_largest_size (o_largest_size),
        .o_bad_index    (o_bad_index)
    );

    // Predictor state: the forest, the set sizes, the running maximum and the
    // node-count bound, all at the block's widths.
    logic [uflc_pkg::NODE_W-1:0] uf_parent [NODES];
    logic [uflc_pkg::SIZE_W-1:0] uf_size   [NODES];
    logic [uflc_pkg::SIZE_W-1:0] uf_max;
    logic [uflc_pkg::CNT_W-1:0]  uf_count;

    t_job         edge_jobs[$];
    t_join_result expected_joins[$];

    int  edges_queued   = 0;
    int  results_seen   = 0;
    int  merges_seen    = 0;
    int  rejects_seen   = 0;
    int  count_writes   = 0;
    int  mismatches     = 0;
    bit  sender_calm    = 1'b0;
    bit  receiver_calm  = 1'b0;
    bit  edge_taken     = 1'b0;
    bit  result_taken   = 1'b0;
    int  hold_cycles    = 0;
    int  ready_hold     = 0;

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic void model_reset();
        for (int i = 0; i < NODES; i++) begin
            uf_parent[i] = i[uflc_pkg::NODE_W-1:0];
            uf_size[i]   = 1;
        end
        uf_max   = 1;
        uf_count = uflc_pkg::CNT_RESET;
    endfunction

    // Walk to the root, relinking every visited node to its grandparent.
    function automatic int unsigned model_find_root(int unsigned v);
        int unsigned steps;
        int unsigned up;
        steps = 0;
        while (uf_parent[v] != v && steps < NODES) begin
            up           = uf_parent[v];
            uf_parent[v] = uf_parent[up];
            v            = uf_parent[v];
            steps++;
        end
        return v;
    endfunction

    function automatic t_join_result model_join(int unsigned a, int unsigned b);
        t_join_result r;
        int unsigned  bound;
        int unsigned  ra;
        int unsigned  rb;
        int unsigned  major;
        int unsigned  minor;
        r.merged  = 1'b0;
        r.bad     = 1'b0;
        bound = (uf_count > NODES) ? NODES : uf_count;
        if (a >= bound || b >= bound) begin
            // Out-of-range endpoint: flagged, and nothing changes.
            r.bad     = 1'b1;
            r.largest = uf_max;
            return r;
        end
        ra = model_find_root(a);
        rb = model_find_root(b);
        if (ra != rb) begin
            // On a tie the root of node_b's set goes under node_a's root.
            major = ra;
            minor = rb;
            if (uf_size[rb] > uf_size[ra]) begin
                major = rb;
                minor = ra;
            end
            uf_parent[minor] = major[uflc_pkg::NODE_W-1:0];
            uf_size[major]   = uf_size[major] + uf_size[minor];
            if (uf_size[major] > uf_max) begin
                uf_max = uf_size[major];
            end
            r.merged = 1'b1;
        end
        r.largest = uf_max;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Work list builders
    // ------------------------------------------------------------------------
    task automatic add_edge(int unsigned a, int unsigned b);
        t_job j;
        j.kind  = JOB_EDGE;
        j.a     = a[uflc_pkg::NODE_W-1:0];
        j.b     = b[uflc_pkg::NODE_W-1:0];
        j.count = '0;
        j.gap   = sender_calm ? 0 : $urandom_range(0, 14);
        edge_jobs.push_back(j);
        edges_queued++;
    endtask

    task automatic add_count(int unsigned n);
        t_job j;
        j.kind  = JOB_COUNT;
        j.a     = '0;
        j.b     = '0;
        j.count = n[uflc_pkg::CNT_W-1:0];
        j.gap   = 0;
        edge_jobs.push_back(j);
    endtask

    task automatic add_drain();
        t_job j;
        j.kind  = JOB_DRAIN;
        j.a     = '0;
        j.b     = '0;
        j.count = '0;
        j.gap   = 0;
        edge_jobs.push_back(j);
    endtask

    // Mostly in-range edges, some of them between neighbors so that chains
    // and deeper trees form; about one in ten is a raw 10-bit pair.
    task automatic add_random_edges(int n, int unsigned count, bit mid_drain);
        int unsigned bound;
        int unsigned a;
        int unsigned b;
        bound = (count > NODES) ? NODES : count;
        for (int i = 0; i < n; i++) begin
            if (mid_drain && i == n / 2) begin
                add_drain();
            end
            if (bound == 0 || $urandom_range(0, 9) == 0) begin
                a = $urandom_range(0, NODES - 1);
                b = $urandom_range(0, NODES - 1);
            end else begin
                a = $urandom_range(0, bound - 1);
                b = $urandom_range(0, bound - 1);
                if ($urandom_range(0, 5) == 0 && a + 1 < bound) begin
                    b = a + 1;
                end
            end
            add_edge(a, b);
        end
    endtask

    // Bound used by the random phase that follows a random node-count write.
    function automatic int unsigned uf_count_of_last_job();
        return edge_jobs[edge_jobs.size() - 1].count;
    endfunction

    // ------------------------------------------------------------------------
    // Sampling at the rising edge: result check first, then the node-count
    // write, then the accepted edge, so the predictor sees them in order.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_join_result want;
        if (!i_rst_n) begin
            model_reset();
        end else begin
            if (o_valid && i_ready) begin
                result_taken = 1'b1;
                if (expected_joins.size() == 0) begin
                    $display("%0t: result with nothing expected: merged %0b size %0d bad %0b",
                             $time, o_merged, o_largest_size, o_bad_index);
                    mismatches++;
                end else begin
                    want = expected_joins.pop_front();
                    results_seen++;
                    if (o_merged !== want.merged) begin
                        $display("%0t: merged expected %0b actual %0b",
                                 $time, want.merged, o_merged);
                        mismatches++;
                    end
                    if (o_largest_size !== want.largest) begin
                        $display("%0t: largest_size expected %0d actual %0d",
                                 $time, want.largest, o_largest_size);
                        mismatches++;
                    end
                    if (o_bad_index !== want.bad) begin
                        $display("%0t: bad_index expected %0b actual %0b",
                                 $time, want.bad, o_bad_index);
                        mismatches++;
                    end
                end
            end
            if (i_cfg_we) begin
                uf_count = i_cfg_data;
                count_writes++;
            end
            if (i_valid && o_ready) begin
                edge_taken = 1'b1;
                want = model_join(i_node_a, i_node_b);
                if (want.merged) merges_seen++;
                if (want.bad) rejects_seen++;
                expected_joins.push_back(want);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Edge driver, on the falling edge. Valid and the write enable each get a
    // single assignment per step, so a back-to-back edge keeps valid high.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        t_job j;
        logic valid_next;
        logic we_next;
        valid_next = i_valid;
        we_next    = 1'b0;
        if (i_rst_n) begin
            if (edge_taken) begin
                edge_taken = 1'b0;
                valid_next = 1'b0;
            end
            if (!valid_next) begin
                if (hold_cycles > 0) begin
                    hold_cycles--;
                end else if (edge_jobs.size() > 0) begin
                    j = edge_jobs[0];
                    case (j.kind)
                        JOB_EDGE: begin
                            void'(edge_jobs.pop_front());
                            i_node_a    <= j.a;
                            i_node_b    <= j.b;
                            valid_next  = 1'b1;
                            hold_cycles = j.gap;
                        end
                        JOB_COUNT: begin
                            // The bound only changes with the block idle.
                            if (expected_joins.size() == 0) begin
                                void'(edge_jobs.pop_front());
                                i_cfg_data <= j.count;
                                we_next    = 1'b1;
                            end
                        end
                        default: begin
                            if (expected_joins.size() == 0) begin
                                void'(edge_jobs.pop_front());
                            end
                        end
                    endcase
                end
            end
        end
        i_valid  <= valid_next;
        i_cfg_we <= we_next;
    end

    // Result side: after each taken result, stall ready for a random number
    // of cycles, except during calm stretches that come and go at random.
    always @(negedge i_clk) begin
        if (result_taken) begin
            result_taken = 1'b0;
            ready_hold   = receiver_calm ? 0 : $urandom_range(0, 14);
            if ($urandom_range(0, 15) == 0) begin
                receiver_calm = ~receiver_calm;
            end
        end
        if (ready_hold > 0) begin
            ready_hold--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        i_clk      = 1'b0;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_data = '0;
        i_valid    = 1'b0;
        i_node_a   = '0;
        i_node_b   = '0;
        i_ready    = 1'b0;

        // Directed part, starting from the reset bound of 1024 nodes: a node
        // joined with itself, merges of equal sizes at both ends of the range,
        // joins within one set, and a smaller set hung under a larger one.
        add_edge(0, 0);
        add_edge(0, 1);
        add_edge(1023, 1022);
        add_edge(1022, 0);
        add_edge(1, 1023);
        add_edge(1023, 1023);
        add_edge(2, 3);
        add_edge(3, 4);
        add_edge(5, 2);
        // A node count of zero rejects every edge.
        add_count(0);
        add_edge(0, 0);
        add_edge(1023, 0);
        // Counts above the node limit saturate.
        add_count(2047);
        add_edge(1023, 512);
        // A single node: only the edge from node 0 to itself is in range.
        add_count(1);
        add_edge(0, 0);
        add_edge(0, 1);
        add_edge(1, 0);
        add_count(1025);
        add_edge(1023, 1023);
        // Endpoints right at the bound and just below it.
        add_count(16);
        add_edge(15, 16);
        add_edge(16, 15);
        add_edge(15, 14);

        // Random phases under several bounds; some phases have no sender gaps,
        // and two pause midway until all results are back.
        sender_calm = 1'b1;
        add_count(32);
        add_random_edges(60, 32, 1'b0);
        sender_calm = 1'b0;
        add_count(1024);
        add_random_edges(70, 1024, 1'b1);
        sender_calm = 1'b1;
        add_count(200);
        add_random_edges(60, 200, 1'b0);
        sender_calm = 1'b0;
        add_count(2047);
        add_random_edges(60, 2047, 1'b0);
        add_count(0);
        add_random_edges(15, 0, 1'b0);
        sender_calm = 1'b1;
        add_count(7);
        add_random_edges(40, 7, 1'b0);
        sender_calm = 1'b0;
        add_count($urandom_range(1, 2047));
        add_random_edges(60, uf_count_of_last_job(), 1'b0);
        add_count(1024);
        add_random_edges(110, 1024, 1'b1);

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Every edge answers exactly once; afterwards keep watching for a
        // while so a stray result would still be caught.
        wait (results_seen == edges_queued);
        repeat (100) @(posedge i_clk);

        $display("Checked %0d edges under %0d node-count writes: %0d merges, %0d rejected.",
                 results_seen, count_writes, merges_seen, rejects_seen);
        $display("Largest set reached %0d nodes.", uf_max);
        if (mismatches == 0) begin
            $display("** union_find_largest_component_top: PASSED **");
        end else begin
            $display("** union_find_largest_component_top: FAILED **");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial begin
        #5ms;
        $display("** union_find_largest_component_top: FAILED **");
        $finish;
    end

endmodule
